FILE: rtl/blsph_pkg.sv
// Shared types and constants of the band level smoother with peak hold.
`default_nettype none

package blsph_pkg;

  localparam int unsigned LEVEL_W = 16;
  localparam int unsigned HOLD_W  = 8;
  localparam int unsigned BAND_W  = 8;
  localparam int unsigned PROD_W  = 2 * LEVEL_W;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 16'hFFFF;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_RISE_FACTOR       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FALL_FACTOR       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_DECAY_FACTOR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_FRAMES       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SILENCE_LEVEL     = 3'd4;

  // Register values after reset
  localparam logic [LEVEL_W-1:0] RISE_FACTOR_RST       = 16'd32768;
  localparam logic [LEVEL_W-1:0] FALL_FACTOR_RST       = 16'd58982;
  localparam logic [LEVEL_W-1:0] PEAK_DECAY_FACTOR_RST = 16'd62259;
  localparam logic [HOLD_W-1:0]  HOLD_FRAMES_RST       = 8'd20;
  localparam logic [LEVEL_W-1:0] SILENCE_LEVEL_RST     = 16'd66;

  typedef struct packed {
    logic [LEVEL_W-1:0] rise_factor;
    logic [LEVEL_W-1:0] fall_factor;
    logic [LEVEL_W-1:0] peak_decay_factor;
    logic [HOLD_W-1:0]  hold_frames;
    logic [LEVEL_W-1:0] silence_level;
  } cfg_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] smooth;
    logic [LEVEL_W-1:0] peak;
    logic [HOLD_W-1:0]  hold;
  } band_state_t;

  // Payload of the stage behind the multipliers
  typedef struct packed {
    logic [BAND_W-1:0]  band;
    logic               out_of_range;
    logic               rising;
    band_state_t        state;
    logic [PROD_W-1:0]  prod_smooth;
    logic [PROD_W-1:0]  prod_peak;
  } mul_t;

endpackage

`default_nettype wire

FILE: rtl/blsph_cfg_regs.sv
// Configuration registers of the band level smoother.
`default_nettype none

module blsph_cfg_regs (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [blsph_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [blsph_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output blsph_pkg::cfg_t                          cfg_o
);

  blsph_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        blsph_pkg::REG_RISE_FACTOR:       cfg_d.rise_factor       = cfg_data_i;
        blsph_pkg::REG_FALL_FACTOR:       cfg_d.fall_factor       = cfg_data_i;
        blsph_pkg::REG_PEAK_DECAY_FACTOR: cfg_d.peak_decay_factor = cfg_data_i;
        blsph_pkg::REG_HOLD_FRAMES:       cfg_d.hold_frames       = cfg_data_i[blsph_pkg::HOLD_W-1:0];
        blsph_pkg::REG_SILENCE_LEVEL:     cfg_d.silence_level     = cfg_data_i;
        default:                          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rise_factor       <= blsph_pkg::RISE_FACTOR_RST;
      cfg_q.fall_factor       <= blsph_pkg::FALL_FACTOR_RST;
      cfg_q.peak_decay_factor <= blsph_pkg::PEAK_DECAY_FACTOR_RST;
      cfg_q.hold_frames       <= blsph_pkg::HOLD_FRAMES_RST;
      cfg_q.silence_level     <= blsph_pkg::SILENCE_LEVEL_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/blsph_band_store.sv
// Per-band state memory with registered read and reset-cleared valid bits.
`default_nettype none

module blsph_band_store #(
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  rd_en_i,
  input  wire logic [AW-1:0]         rd_addr_i,
  output blsph_pkg::band_state_t     rd_state_o,
  input  wire logic                  we_i,
  input  wire logic [AW-1:0]         wr_addr_i,
  input  wire blsph_pkg::band_state_t wr_state_i
);

  blsph_pkg::band_state_t mem_q [DEPTH];
  blsph_pkg::band_state_t rd_data_q;
  logic [DEPTH-1:0]       valid_q;
  logic                   rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wr_addr_i] <= wr_state_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // An entry never written since reset reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_state_o = rd_valid_q ? rd_data_q : '0;

endmodule

`default_nettype wire

FILE: rtl/blsph_mul_stage.sv
// Multiply stage: picks attack or fall operands and forms both Q0.32 products.
`default_nettype none

module blsph_mul_stage #(
  parameter int unsigned NUM_BANDS = 256
) (
  input  wire logic                              clk_i,
  input  wire logic                              load_i,
  input  wire logic [blsph_pkg::BAND_W-1:0]      band_i,
  input  wire logic [blsph_pkg::LEVEL_W-1:0]     target_i,
  input  wire blsph_pkg::band_state_t            state_i,
  input  wire blsph_pkg::cfg_t                   cfg_i,
  output blsph_pkg::mul_t                        stage_o
);

  blsph_pkg::mul_t                 stage_q, stage_d;
  logic                            rising;
  logic [blsph_pkg::LEVEL_W-1:0]   op_level;
  logic [blsph_pkg::LEVEL_W-1:0]   op_factor;

  always_comb begin
    rising    = target_i > state_i.smooth;
    op_level  = rising ? (target_i - state_i.smooth) : state_i.smooth;
    op_factor = rising ? cfg_i.rise_factor : cfg_i.fall_factor;

    stage_d.band         = band_i;
    stage_d.out_of_range = 32'(band_i) >= 32'(NUM_BANDS);
    stage_d.rising       = rising;
    stage_d.state        = state_i;
    stage_d.prod_smooth  = blsph_pkg::PROD_W'(op_level) * blsph_pkg::PROD_W'(op_factor);
    stage_d.prod_peak    = blsph_pkg::PROD_W'(state_i.peak)
                         * blsph_pkg::PROD_W'(cfg_i.peak_decay_factor);
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

`default_nettype wire

FILE: rtl/blsph_update.sv
// Update logic: new smoothed level, peak hold and silence gate for one band.
`default_nettype none

module blsph_update (
  input  wire blsph_pkg::mul_t                   stage_i,
  input  wire blsph_pkg::cfg_t                   cfg_i,
  output blsph_pkg::band_state_t                 state_o,
  output logic [blsph_pkg::LEVEL_W-1:0]          smooth_o,
  output logic [blsph_pkg::LEVEL_W-1:0]          peak_o
);

  logic [blsph_pkg::LEVEL_W:0]     sum;
  logic [blsph_pkg::LEVEL_W-1:0]   smooth;
  logic [blsph_pkg::LEVEL_W-1:0]   step;
  logic [blsph_pkg::LEVEL_W-1:0]   decayed;

  always_comb begin
    step    = stage_i.prod_smooth[blsph_pkg::PROD_W-1:blsph_pkg::LEVEL_W];
    decayed = stage_i.prod_peak[blsph_pkg::PROD_W-1:blsph_pkg::LEVEL_W];

    if (stage_i.rising) begin
      sum = {1'b0, stage_i.state.smooth} + {1'b0, step};
    end else begin
      sum = {1'b0, step};
    end
    smooth = sum[blsph_pkg::LEVEL_W] ? blsph_pkg::LEVEL_MAX : sum[blsph_pkg::LEVEL_W-1:0];

    state_o.smooth = smooth;
    if (smooth >= stage_i.state.peak) begin
      // reaching the peak counts as a new peak
      state_o.peak = smooth;
      state_o.hold = cfg_i.hold_frames;
    end else if (stage_i.state.hold != '0) begin
      state_o.peak = stage_i.state.peak;
      state_o.hold = stage_i.state.hold - blsph_pkg::HOLD_W'(1);
    end else begin
      state_o.peak = decayed;
      state_o.hold = stage_i.state.hold;
    end

    if (smooth < cfg_i.silence_level) begin
      state_o = '0;
    end

    smooth_o = stage_i.out_of_range ? '0 : state_o.smooth;
    peak_o   = stage_i.out_of_range ? '0 : state_o.peak;
  end

endmodule

`default_nettype wire

FILE: rtl/band_level_smoother_peak_hold.sv
// Top level of the band level smoother with peak hold meter.
//
// One input word carries a band number (s_axis_tuser) and that band's raw
// level in unsigned Q0.16 (s_axis_tdata). For each word one result word leaves
// on the master side: the band number (m_axis_tuser) with the updated smoothed
// and peak levels (m_axis_tdata). Per band the block keeps smoothed level, peak
// and hold count in an internal memory.
// Pipeline: memory read (1) -> multiply (2) -> update and write-back (3). A
// result word is presented from the output register loaded with the write-back;
// one word a cycle is taken unless a band hazard or a receiver stall holds the
// input. A word for a band still in stage 1 or 2 waits until that earlier
// update has been written back.
// Bands at or above NUM_BANDS leave the state alone and return zero levels.
// Reset clears the configuration to its defaults and marks every band empty
// (valid bits), so all bands start at zero; no clearing pass is needed.
// When the receiver stalls, the output register holds its word and each stage
// holds only if the one behind it is full, so bubbles still close up.
// Configuration is written through cfg_we_i/cfg_index_i/cfg_data_i while the
// pipeline is empty; indexes beyond the register list are ignored.
`default_nettype none

module band_level_smoother_peak_hold #(
  parameter int unsigned NUM_BANDS = 256
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // input channel
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [15:0]  s_axis_tdata,   // [15:0] raw_level
  input  wire logic [7:0]   s_axis_tuser,   // [7:0] band_index
  // output channel
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [31:0]       m_axis_tdata,   // [15:0] smooth_level, [31:16] peak_level
  output logic [7:0]        m_axis_tuser,   // [7:0] out_band
  // configuration write port
  input  wire logic         cfg_we_i,
  input  wire logic [2:0]   cfg_index_i,
  input  wire logic [15:0]  cfg_data_i
);

  // Only the bands an 8-bit index can reach need storage
  localparam int unsigned DEPTH = (NUM_BANDS < 256) ? NUM_BANDS : 256;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  blsph_pkg::cfg_t         cfg;
  blsph_pkg::band_state_t  rd_state;
  blsph_pkg::band_state_t  new_state;
  blsph_pkg::mul_t         mul_stage;

  logic                              v1_q, v2_q, v3_q;
  logic                              rdy1, rdy2, rdy3;
  logic                              hazard;
  logic                              in_accept;
  logic                              wr_en;
  logic [blsph_pkg::BAND_W-1:0]      band1_q;
  logic [blsph_pkg::LEVEL_W-1:0]     target1_q;
  logic [blsph_pkg::BAND_W-1:0]      band3_q;
  logic [blsph_pkg::LEVEL_W-1:0]     smooth3_q, peak3_q;
  logic [blsph_pkg::LEVEL_W-1:0]     smooth_res, peak_res;

  // Each stage advances when the stage after it is empty or moving
  assign rdy3 = !v3_q || m_axis_tready;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  // Hold off a band whose earlier update has not reached the memory yet
  assign hazard = (v1_q && (band1_q == s_axis_tuser))
               || (v2_q && (mul_stage.band == s_axis_tuser));

  assign s_axis_tready = rdy1 && !hazard;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign wr_en         = v2_q && rdy3 && !mul_stage.out_of_range;

  blsph_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  blsph_band_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (in_accept),
    .rd_addr_i  (s_axis_tuser[AW-1:0]),
    .rd_state_o (rd_state),
    .we_i       (wr_en),
    .wr_addr_i  (mul_stage.band[AW-1:0]),
    .wr_state_i (new_state)
  );

  blsph_mul_stage #(
    .NUM_BANDS (NUM_BANDS)
  ) u_mul (
    .clk_i    (clk_i),
    .load_i   (v1_q && rdy2),
    .band_i   (band1_q),
    .target_i (target1_q),
    .state_i  (rd_state),
    .cfg_i    (cfg),
    .stage_o  (mul_stage)
  );

  blsph_update u_update (
    .stage_i  (mul_stage),
    .cfg_i    (cfg),
    .state_o  (new_state),
    .smooth_o (smooth_res),
    .peak_o   (peak_res)
  );

  // Stage 1 payload: captured with the memory read
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      band1_q   <= s_axis_tuser;
      target1_q <= s_axis_tdata;
    end
  end

  // Output register: loaded in step with the write-back
  always_ff @(posedge clk_i) begin
    if (v2_q && rdy3) begin
      band3_q   <= mul_stage.band;
      smooth3_q <= smooth_res;
      peak3_q   <= peak_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_accept;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  assign m_axis_tvalid = v3_q;
  assign m_axis_tuser  = band3_q;
  assign m_axis_tdata  = {peak3_q, smooth3_q};

  // Two updates of one band never sit in the read and multiply stages together
  a_no_band_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && v2_q) |-> (band1_q != mul_stage.band))
    else $error("same band in stage 1 and stage 2");

  // A word leaving the multiply stage lands in the output register
  a_stage2_to_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && rdy3) |=> v3_q)
    else $error("result lost between stage 2 and output");

  // A nonzero smoothed level is never below the silence level
  a_silence_gate : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[15:0] != '0))
      |-> (m_axis_tdata[15:0] >= cfg.silence_level))
    else $error("smoothed level below silence level");

  // Bands without storage return zero levels
  a_out_of_range_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (32'(m_axis_tuser) >= 32'(NUM_BANDS))) |-> (m_axis_tdata == '0))
    else $error("out-of-range band returned nonzero levels");

endmodule

`default_nettype wire

FILE: tb/sv/tb_band_level_smoother_peak_hold.sv
// Self-checking testbench for the band level smoother with peak hold.
module tb_band_level_smoother_peak_hold;
  timeunit 1ns;
  timeprecision 1ps;

  import blsph_pkg::*;

  localparam int unsigned NUM_BANDS   = 256;
  localparam int unsigned LONG_HOLD   = 300;   // receiver hold-off for the pressure test
  localparam int unsigned PHASE_WORDS = 255;
  localparam int unsigned NUM_PHASES  = 6;

  // One result word as the block should deliver it
  typedef struct packed {
    logic [BAND_W-1:0]  band;
    logic [LEVEL_W-1:0] smooth;
    logic [LEVEL_W-1:0] peak;
  } level_result_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [15:0]           s_axis_tdata  = '0;   // [15:0] raw_level
  logic [7:0]            s_axis_tuser  = '0;   // [7:0] band_index
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [31:0]           m_axis_tdata;         // [15:0] smooth_level, [31:16] peak_level
  logic [7:0]            m_axis_tuser;         // [7:0] out_band
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  band_level_smoother_peak_hold #(
    .NUM_BANDS(NUM_BANDS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // Meter state as the block should hold it
  cfg_t                meter_cfg;
  logic [LEVEL_W-1:0]  band_smooth_q [NUM_BANDS];
  logic [LEVEL_W-1:0]  band_peak_q   [NUM_BANDS];
  logic [HOLD_W-1:0]   band_hold_q   [NUM_BANDS];
  level_result_t       levels_due[$];

  int unsigned fail_count    = 0;
  int unsigned src_idle_pct  = 0;   // chance of a gap before each input word
  int unsigned sink_idle_pct = 0;   // chance of the receiver stalling on a cycle
  int unsigned hold_requests = 0;   // raised by a test, served by the receiver
  int unsigned hold_served   = 0;
  int unsigned sink_stall_left = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hard stop in case the block hangs
  initial begin
    #20ms;
    $display("tb_band_level_smoother_peak_hold: errors");
    $finish;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap(input int unsigned idle_pct);
    if ($urandom_range(99) >= idle_pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(40, 8);
    return $urandom_range(3, 1);
  endfunction

  // Bias towards the extremes and silence so that decay and zeroing get hit
  function automatic logic [LEVEL_W-1:0] pick_level();
    case ($urandom_range(7))
      0, 1:    return '0;
      2:       return LEVEL_MAX;
      3:       return LEVEL_W'($urandom_range(200));
      default: return LEVEL_W'($urandom);
    endcase
  endfunction

  // Advance one band's smoothed level, peak and hold count; return the result word
  function automatic level_result_t advance_band(input logic [BAND_W-1:0]  band,
                                                 input logic [LEVEL_W-1:0] target);
    level_result_t res;
    logic [31:0]   s;
    logic [31:0]   p;
    logic [HOLD_W-1:0] h;
    res.band   = band;
    res.smooth = '0;
    res.peak   = '0;
    if (band >= NUM_BANDS) return res;   // band out of range: state untouched
    s = band_smooth_q[band];
    p = band_peak_q[band];
    h = band_hold_q[band];
    // attack closes part of the gap, release scales down
    if (target > s) s = s + ((meter_cfg.rise_factor * (target - s)) >> LEVEL_W);
    else            s = (s * meter_cfg.fall_factor) >> LEVEL_W;
    if (s > LEVEL_MAX) s = LEVEL_MAX;
    // reaching the peak (equal included) reloads the hold
    if (s >= p) begin
      p = s;
      h = meter_cfg.hold_frames;
    end else if (h != 0) begin
      h = h - 1'b1;
    end else begin
      p = (p * meter_cfg.peak_decay_factor) >> LEVEL_W;
    end
    if (p > LEVEL_MAX) p = LEVEL_MAX;
    // silence overrides everything, judged on the new smoothed level
    if (s < meter_cfg.silence_level) begin
      s = 0;
      p = 0;
      h = 0;
    end
    band_smooth_q[band] = s[LEVEL_W-1:0];
    band_peak_q[band]   = p[LEVEL_W-1:0];
    band_hold_q[band]   = h;
    res.smooth = s[LEVEL_W-1:0];
    res.peak   = p[LEVEL_W-1:0];
    return res;
  endfunction

  function automatic void report(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, field, want, got);
  endfunction

  // Check each result word against the oldest prediction, then predict for the
  // input word taken at this edge. Both handshakes are sampled before the edge.
  always @(posedge clk_i) begin : check_results
    level_result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (levels_due.size() == 0) begin
          report("unexpected result word (band)", '0, m_axis_tuser);
        end else begin
          want = levels_due.pop_front();
          if (m_axis_tuser !== want.band) report("out_band", want.band, m_axis_tuser);
          if (m_axis_tdata[15:0] !== want.smooth)
            report("smooth_level", want.smooth, m_axis_tdata[15:0]);
          if (m_axis_tdata[31:16] !== want.peak)
            report("peak_level", want.peak, m_axis_tdata[31:16]);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        levels_due.push_back(advance_band(s_axis_tuser, s_axis_tdata));
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever a test asks for one
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (hold_requests != hold_served) begin
        hold_served++;
        sink_stall_left = LONG_HOLD;
      end
      if (sink_stall_left > 0) begin
        sink_stall_left--;
        m_axis_tready <= 1'b0;
      end else if ($urandom_range(99) < sink_idle_pct) begin
        sink_stall_left = pick_gap(100) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Offer one word and hold it until taken; valid stays high for a back-to-back word
  task automatic send_level(input logic [BAND_W-1:0] band, input logic [LEVEL_W-1:0] level);
    int unsigned gap;
    gap = pick_gap(src_idle_pct);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= level;
    s_axis_tuser  <= band;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Drop valid and wait until every outstanding result word has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (levels_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    // the block takes the write at this edge
    case (idx)
      REG_RISE_FACTOR:       meter_cfg.rise_factor       = value;
      REG_FALL_FACTOR:       meter_cfg.fall_factor       = value;
      REG_PEAK_DECAY_FACTOR: meter_cfg.peak_decay_factor = value;
      REG_HOLD_FRAMES:       meter_cfg.hold_frames       = value[HOLD_W-1:0];
      REG_SILENCE_LEVEL:     meter_cfg.silence_level     = value;
      default: ;
    endcase
    cfg_we_i <= 1'b0;
  endtask

  // Reset settings: full-scale rise on the end bands, a back-to-back repeat of one
  // band, a fall, and a fresh band fed silence
  task automatic test_reset_defaults();
    send_level(8'd0,   LEVEL_MAX);
    send_level(8'd0,   LEVEL_MAX);
    send_level(8'd255, LEVEL_MAX);
    send_level(8'd255, 16'd0);
    send_level(8'd0,   16'd0);
    send_level(8'd1,   16'd0);
    send_level(8'd0,   16'h8000);
  endtask

  // Zero hold: the peak must decay on the first update after it stops rising
  task automatic test_zero_hold();
    write_reg(REG_HOLD_FRAMES, 16'd0);
    send_level(8'd2, LEVEL_MAX);
    send_level(8'd2, 16'd0);
    send_level(8'd2, 16'd0);
    send_level(8'd2, 16'd0);
  endtask

  // Registers at both ends of their ranges; repeated full-scale words give a
  // smoothed level equal to the peak, which must reload the hold
  task automatic test_register_extremes();
    write_reg(REG_RISE_FACTOR,       LEVEL_MAX);
    write_reg(REG_FALL_FACTOR,       16'd0);
    write_reg(REG_PEAK_DECAY_FACTOR, 16'd0);
    write_reg(REG_HOLD_FRAMES,       16'd255);
    write_reg(REG_SILENCE_LEVEL,     16'd0);
    send_level(8'd3, LEVEL_MAX);
    send_level(8'd3, LEVEL_MAX);
    send_level(8'd3, 16'd0);
    send_level(8'd3, 16'd1);
    write_reg(REG_RISE_FACTOR,       16'd0);
    write_reg(REG_FALL_FACTOR,       LEVEL_MAX);
    write_reg(REG_PEAK_DECAY_FACTOR, LEVEL_MAX);
    write_reg(REG_HOLD_FRAMES,       16'd0);
    write_reg(REG_SILENCE_LEVEL,     LEVEL_MAX);
    send_level(8'd4,   LEVEL_MAX);
    send_level(8'd255, LEVEL_MAX);
    send_level(8'd3,   16'd1);
  endtask

  // A register value: often an extreme, otherwise random within a useful span
  function automatic logic [CFG_DATA_W-1:0] pick_setting(input logic [CFG_DATA_W-1:0] top,
                                                         input logic [CFG_DATA_W-1:0] span);
    case ($urandom_range(5))
      0:       return '0;
      1:       return top;
      2:       return CFG_DATA_W'($urandom) & top;
      default: return CFG_DATA_W'($urandom_range(span));
    endcase
  endfunction

  // Random words under random settings; a few hot bands give repeats and long
  // histories, the rest spread over all bands
  task automatic test_random_traffic(input int unsigned phase);
    logic [BAND_W-1:0] band;
    write_reg(REG_RISE_FACTOR,       pick_setting(LEVEL_MAX, LEVEL_MAX));
    write_reg(REG_FALL_FACTOR,       pick_setting(LEVEL_MAX, LEVEL_MAX));
    write_reg(REG_PEAK_DECAY_FACTOR, pick_setting(LEVEL_MAX, LEVEL_MAX));
    write_reg(REG_HOLD_FRAMES,       pick_setting(16'd255, 16'd24));
    write_reg(REG_SILENCE_LEVEL,     pick_setting(LEVEL_MAX, 16'd2000));
    // every third phase runs without idling on either side
    src_idle_pct  = (phase % 3 == 0) ? 0 : $urandom_range(60, 10);
    sink_idle_pct = (phase % 3 == 0) ? 0 : $urandom_range(60, 10);
    repeat (PHASE_WORDS) begin
      band = $urandom_range(1) ? BAND_W'($urandom_range(3)) : BAND_W'($urandom);
      send_level(band, pick_level());
    end
    src_idle_pct  = 0;
    sink_idle_pct = 0;
  endtask

  // Hold the receiver off while words keep coming, so the pipeline fills and
  // the input stalls
  task automatic test_backpressure();
    drain();
    hold_requests++;
    repeat (40) send_level(BAND_W'($urandom_range(7)), pick_level());
  endtask

  initial begin
    meter_cfg.rise_factor       = RISE_FACTOR_RST;
    meter_cfg.fall_factor       = FALL_FACTOR_RST;
    meter_cfg.peak_decay_factor = PEAK_DECAY_FACTOR_RST;
    meter_cfg.hold_frames       = HOLD_FRAMES_RST;
    meter_cfg.silence_level     = SILENCE_LEVEL_RST;
    for (int i = 0; i < NUM_BANDS; i++) begin
      band_smooth_q[i] = '0;
      band_peak_q[i]   = '0;
      band_hold_q[i]   = '0;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_zero_hold();
    test_register_extremes();
    for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
      test_random_traffic(ph);
      if (ph == 1) test_backpressure();
    end

    drain();
    // allow for the pipeline depth so a stray word would still be caught
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && levels_due.size() == 0) begin
      $display("tb_band_level_smoother_peak_hold: clean");
    end else begin
      $display("tb_band_level_smoother_peak_hold: errors");
    end
    $finish;
  end

endmodule
